// ===== rtl/core/tcs_pkg.sv =====
// types and constants shared by the text console with scrollback
// no dependencies

package tcs_pkg;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_SCROLL = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_OP,
    S_MUL,
    S_WRITE,
    S_RREQ,
    S_RDATA,
    S_CLEAR,
    S_FOLLOW,
    S_VIS,
    S_POS,
    S_DONE
  } state_e;

  // store and screen geometry, fixed by the widths of the result ports
  localparam int SCROLLBACK_LINES = 1024;
  localparam int SCREEN_COLS      = 80;
  localparam int SCREEN_ROWS      = 25;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h02;

endpackage

// ===== rtl/core/tcs_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

module tcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/text_console_scrollback.sv =====
// text console with scrollback: sequencer, cursor and view state, shared multiply-add
// depends on tcs_pkg and tcs_ram
//
// usage: present an operation on mode_i and its operand ports with start high;
// it is taken at a clock edge where start is high and busy is low. busy stays
// high until the result has been shown. each operation gives one result on the
// result ports, valid for exactly one cycle while done_o is high; the receiver
// cannot hold it off, so it must take the transfer in that cycle.
// the attribute register is written over the cfg channel (cfg_ready_o is
// always high); write it only while busy is low.
// the sequencer steps share one multiply-add unit (line * cols + col) and the store;
// a clear writes blanks over the rows it covers, one cell per cycle.
// one operation is in flight at a time.
// after reset busy is high while the store is filled with spaces; cursor, view
// top and attribute come out of reset at once.

module text_console_scrollback (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [10:0] scroll_amount_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  output logic               done_o,
  output logic [6:0]         cursor_col_o,
  output logic [4:0]         cursor_row_o,
  output logic [10:0]        cursor_position_o,
  output logic               cursor_visible_o,
  output logic [9:0]         view_top_o,
  output logic [9:0]         cursor_line_o,
  output logic [7:0]         read_char_o,
  output logic [7:0]         read_attr_o,
  output logic               overflow_o
);

  localparam int LW    = $clog2(tcs_pkg::SCROLLBACK_LINES);
  localparam int CW    = $clog2(tcs_pkg::SCREEN_COLS);
  localparam int RW    = $clog2(tcs_pkg::SCREEN_ROWS);
  localparam int DEPTH = tcs_pkg::SCROLLBACK_LINES * tcs_pkg::SCREEN_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((LW > 7) ? LW : 7) + 2;
  localparam int SW    = ((LW > 11) ? LW : 11) + 2;

  localparam logic [LW-1:0] LAST_LINE = LW'(tcs_pkg::SCROLLBACK_LINES - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(tcs_pkg::SCREEN_COLS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(tcs_pkg::SCREEN_ROWS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  tcs_pkg::state_e state_q, state_d;

  // cursor and view
  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] line_q, line_d;
  logic [LW-1:0] top_q, top_d;
  logic          shown_q, shown_d;
  logic [7:0]    attr_q;

  // latched operation
  tcs_pkg::mode_e    mode_q, mode_d;
  logic [7:0]        char_q, char_d;
  logic signed [10:0] scroll_q, scroll_d;
  logic [4:0]        rrow_q, rrow_d;
  logic [6:0]        rcol_q, rcol_d;

  // working registers
  logic [RW-1:0] crow_q, crow_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    rch_q, rch_d;
  logic [LW-1:0] opa_q, opa_d;
  logic [CW-1:0] opb_q, opb_d;
  logic [7:0]    wdata_q, wdata_d;
  logic [AW-1:0] prod_q, prod_d;
  logic [AW-1:0] swp_q, swp_d;
  logic [CW-1:0] cl_col_q, cl_col_d;
  logic [RW-1:0] cl_row_q, cl_row_d;
  logic [LW-1:0] cl_line_q, cl_line_d;

  // shared multiply-add and store port
  logic [LW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [AW-1:0] mul_res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  // derived values
  logic              at_end;
  logic [LW-1:0]     nxt_line;
  logic signed [SW-1:0] scroll_tgt;
  logic [XW-1:0]     rd_line;
  logic              rd_ok;
  logic              line_lt;
  logic [XW-1:0]     span;
  logic              in_view;

  assign mul_res = AW'(AW'(mul_a) * AW'(tcs_pkg::SCREEN_COLS)) + AW'(mul_b);

  assign at_end   = (line_q == LAST_LINE);
  assign nxt_line = at_end ? line_q : line_q + 1'b1;

  assign scroll_tgt = $signed(SW'(top_q)) + SW'(scroll_q);

  assign rd_line = XW'(top_q) + XW'(rrow_q);
  assign rd_ok   = (XW'(rrow_q) < XW'(tcs_pkg::SCREEN_ROWS))
                && (XW'(rcol_q) < XW'(tcs_pkg::SCREEN_COLS))
                && (rd_line < XW'(tcs_pkg::SCROLLBACK_LINES));

  assign line_lt = (line_q < top_q);
  assign span    = XW'(line_q) - XW'(top_q);
  assign in_view = !line_lt && (span < XW'(tcs_pkg::SCREEN_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcs_pkg::S_INIT;
      swp_q   <= '0;
      col_q   <= '0;
      line_q  <= '0;
      top_q   <= '0;
      shown_q <= 1'b1;
      attr_q  <= tcs_pkg::ATTR_RESET;
    end else begin
      state_q <= state_d;
      swp_q   <= swp_d;
      col_q   <= col_d;
      line_q  <= line_d;
      top_q   <= top_d;
      shown_q <= shown_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    char_q    <= char_d;
    scroll_q  <= scroll_d;
    rrow_q    <= rrow_d;
    rcol_q    <= rcol_d;
    crow_q    <= crow_d;
    ovf_q     <= ovf_d;
    rch_q     <= rch_d;
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    wdata_q   <= wdata_d;
    prod_q    <= prod_d;
    cl_col_q  <= cl_col_d;
    cl_row_q  <= cl_row_d;
    cl_line_q <= cl_line_d;
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    line_d    = line_q;
    top_d     = top_q;
    shown_d   = shown_q;
    mode_d    = mode_q;
    char_d    = char_q;
    scroll_d  = scroll_q;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    crow_d    = crow_q;
    ovf_d     = ovf_q;
    rch_d     = rch_q;
    opa_d     = opa_q;
    opb_d     = opb_q;
    wdata_d   = wdata_q;
    prod_d    = prod_q;
    swp_d     = swp_q;
    cl_col_d  = cl_col_q;
    cl_row_d  = cl_row_q;
    cl_line_d = cl_line_q;
    mul_a     = opa_q;
    mul_b     = opb_q;
    ram_we    = 1'b0;
    ram_waddr = prod_q;
    ram_wdata = wdata_q;
    ram_re    = 1'b0;
    done_o    = 1'b0;

    unique case (state_q)
      tcs_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = swp_q;
        ram_wdata = tcs_pkg::CHAR_BLANK;
        if (swp_q == LAST_ADDR) begin
          state_d = tcs_pkg::S_IDLE;
        end else begin
          swp_d = swp_q + 1'b1;
        end
      end

      tcs_pkg::S_IDLE: begin
        if (start) begin
          mode_d   = tcs_pkg::mode_e'(mode_i);
          char_d   = char_code_i;
          scroll_d = scroll_amount_i;
          rrow_d   = read_row_i;
          rcol_d   = read_col_i;
          state_d  = tcs_pkg::S_OP;
        end
      end

      tcs_pkg::S_OP: begin
        rch_d = '0;
        ovf_d = 1'b0;
        unique case (mode_q)
          tcs_pkg::MODE_PUT: begin
            unique case (char_q) inside
              tcs_pkg::CHAR_LF, tcs_pkg::CHAR_CR: begin
                col_d   = '0;
                line_d  = nxt_line;
                ovf_d   = at_end;
                state_d = tcs_pkg::S_FOLLOW;
              end
              tcs_pkg::CHAR_BS: begin
                wdata_d = tcs_pkg::CHAR_BLANK;
                if (col_q == '0 && line_q == '0) begin
                  state_d = tcs_pkg::S_FOLLOW;
                end else if (col_q == '0) begin
                  // wrap back to the last cell of the previous line
                  line_d  = line_q - 1'b1;
                  col_d   = LAST_COL;
                  opa_d   = line_q - 1'b1;
                  opb_d   = LAST_COL;
                  state_d = tcs_pkg::S_MUL;
                end else begin
                  col_d   = col_q - 1'b1;
                  opa_d   = line_q;
                  opb_d   = col_q - 1'b1;
                  state_d = tcs_pkg::S_MUL;
                end
              end
              default: begin
                wdata_d = char_q;
                opa_d   = line_q;
                opb_d   = col_q;
                if (col_q == LAST_COL) begin
                  col_d  = '0;
                  line_d = nxt_line;
                  ovf_d  = at_end;
                end else begin
                  col_d = col_q + 1'b1;
                end
                state_d = tcs_pkg::S_MUL;
              end
            endcase
          end
          tcs_pkg::MODE_SCROLL: begin
            if (scroll_tgt[SW-1]) begin
              top_d = '0;
            end else if (scroll_tgt > $signed(SW'(line_q))) begin
              top_d = line_q;
            end else begin
              top_d = LW'(scroll_tgt);
            end
            state_d = tcs_pkg::S_VIS;
          end
          tcs_pkg::MODE_CLEAR: begin
            col_d     = '0;
            line_d    = nxt_line;
            top_d     = nxt_line;
            ovf_d     = at_end;
            opa_d     = nxt_line;
            opb_d     = '0;
            cl_col_d  = '0;
            cl_row_d  = '0;
            cl_line_d = nxt_line;
            state_d   = tcs_pkg::S_MUL;
          end
          tcs_pkg::MODE_READ: begin
            rch_d = tcs_pkg::CHAR_BLANK;
            if (rd_ok) begin
              opa_d   = LW'(rd_line);
              opb_d   = CW'(rcol_q);
              state_d = tcs_pkg::S_MUL;
            end else begin
              state_d = tcs_pkg::S_VIS;
            end
          end
        endcase
      end

      tcs_pkg::S_MUL: begin
        prod_d = mul_res;
        unique case (mode_q)
          tcs_pkg::MODE_PUT:   state_d = tcs_pkg::S_WRITE;
          tcs_pkg::MODE_READ:  state_d = tcs_pkg::S_RREQ;
          tcs_pkg::MODE_CLEAR: begin
            swp_d   = mul_res;
            state_d = tcs_pkg::S_CLEAR;
          end
          tcs_pkg::MODE_SCROLL: state_d = tcs_pkg::S_VIS;
        endcase
      end

      tcs_pkg::S_WRITE: begin
        ram_we  = 1'b1;
        state_d = tcs_pkg::S_FOLLOW;
      end

      tcs_pkg::S_RREQ: begin
        ram_re  = 1'b1;
        state_d = tcs_pkg::S_RDATA;
      end

      tcs_pkg::S_RDATA: begin
        rch_d   = ram_rdata;
        state_d = tcs_pkg::S_VIS;
      end

      tcs_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = swp_q;
        ram_wdata = tcs_pkg::CHAR_BLANK;
        swp_d     = swp_q + 1'b1;
        if (cl_col_q == LAST_COL) begin
          // stop after a full page or at the end of the store
          if (cl_row_q == LAST_ROW || cl_line_q == LAST_LINE) begin
            state_d = tcs_pkg::S_VIS;
          end else begin
            cl_col_d  = '0;
            cl_row_d  = cl_row_q + 1'b1;
            cl_line_d = cl_line_q + 1'b1;
          end
        end else begin
          cl_col_d = cl_col_q + 1'b1;
        end
      end

      tcs_pkg::S_FOLLOW: begin
        // when the cursor left the page, move the view so it sits on the bottom row (or the view starts at line 0)
        if (line_lt || span >= XW'(tcs_pkg::SCREEN_ROWS)) begin
          if (XW'(line_q) >= XW'(tcs_pkg::SCREEN_ROWS - 1)) begin
            top_d = LW'(XW'(line_q) - XW'(tcs_pkg::SCREEN_ROWS - 1));
          end else begin
            top_d = '0;
          end
        end
        state_d = tcs_pkg::S_VIS;
      end

      tcs_pkg::S_VIS: begin
        shown_d = in_view;
        crow_d  = in_view ? RW'(span) : '0;
        state_d = tcs_pkg::S_POS;
      end

      tcs_pkg::S_POS: begin
        mul_a   = LW'(crow_q);
        mul_b   = col_q;
        prod_d  = mul_res;
        state_d = tcs_pkg::S_DONE;
      end

      tcs_pkg::S_DONE: begin
        done_o  = 1'b1;
        state_d = tcs_pkg::S_IDLE;
      end

      default: state_d = tcs_pkg::S_IDLE;
    endcase
  end

  tcs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (prod_q),
    .rdata_o (ram_rdata)
  );

  assign busy              = (state_q != tcs_pkg::S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign cursor_col_o      = 7'(col_q);
  assign cursor_row_o      = 5'(crow_q);
  assign cursor_position_o = shown_q ? 11'(prod_q) : '0;
  assign cursor_visible_o  = shown_q;
  assign view_top_o        = 10'(top_q);
  assign cursor_line_o     = 10'(line_q);
  assign read_char_o       = rch_q;
  assign read_attr_o       = (mode_q == tcs_pkg::MODE_READ) ? attr_q : '0;
  assign overflow_o        = ovf_q;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside an operation");

  a_accept_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == tcs_pkg::S_OP))
    else $error("accepted operation did not start");

  a_top_le_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (top_q <= line_q))
    else $error("view top below the cursor line at result");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcs_pkg::S_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !cursor_visible_o) |-> (cursor_row_o == '0 && cursor_position_o == '0))
    else $error("hidden cursor reports a position");

endmodule

// ===== bench/tcs_console_checker.sv =====
// checker for the text console with scrollback: watches the operation, result and attribute
// channels, predicts each result from its own copy of cursor, view, attribute and store
// depends on tcs_pkg

module tcs_console_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [10:0] scroll_amount_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               done_o,
  input  logic [6:0]         cursor_col_o,
  input  logic [4:0]         cursor_row_o,
  input  logic [10:0]        cursor_position_o,
  input  logic               cursor_visible_o,
  input  logic [9:0]         view_top_o,
  input  logic [9:0]         cursor_line_o,
  input  logic [7:0]         read_char_o,
  input  logic [7:0]         read_attr_o,
  input  logic               overflow_o,
  output int                 fail_count_o,
  output int                 outstanding_o,
  output int                 cursor_line_pred_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = tcs_pkg::SCROLLBACK_LINES;
  localparam int COLS  = tcs_pkg::SCREEN_COLS;
  localparam int ROWS  = tcs_pkg::SCREEN_ROWS;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic        vis;
    logic [9:0]  vtop;
    logic [9:0]  line;
    logic [7:0]  rch;
    logic [7:0]  rattr;
    logic        ovf;
  } console_result_t;

  int         col_q;
  int         line_q;
  int         vtop_q;
  bit         shown_q;
  logic [7:0] attr_q;
  logic [7:0] char_store [LINES*COLS];

  console_result_t expected_results [$];
  int failures = 0;

  assign fail_count_o = failures;

  task automatic step_line(output bit ovf);
    if (line_q + 1 < LINES) begin
      line_q++;
      ovf = 1'b0;
    end else begin
      ovf = 1'b1;
    end
  endtask

  function automatic void update_visibility();
    shown_q = (line_q >= vtop_q) && (line_q - vtop_q < ROWS);
  endfunction

  task automatic predict_console_op(input tcs_pkg::mode_e op, input logic [7:0] ch,
                                    input logic signed [10:0] amt, input logic [4:0] rrow,
                                    input logic [6:0] rcol, output console_result_t res);
    int target;
    int ln;
    bit ovf;
    ovf = 1'b0;
    res = '0;
    case (op)
      tcs_pkg::MODE_PUT: begin
        // backspace at the origin leaves everything as it is
        if (!(ch == tcs_pkg::CHAR_BS && col_q == 0 && line_q == 0)) begin
          if (ch == tcs_pkg::CHAR_LF || ch == tcs_pkg::CHAR_CR) begin
            step_line(ovf);
            col_q = 0;
          end else if (ch == tcs_pkg::CHAR_BS) begin
            if (col_q == 0) begin
              line_q--;
              col_q = COLS - 1;
            end else begin
              col_q--;
            end
            char_store[line_q*COLS + col_q] = tcs_pkg::CHAR_BLANK;
          end else begin
            char_store[line_q*COLS + col_q] = ch;
            col_q++;
            if (col_q >= COLS) begin
              col_q = 0;
              step_line(ovf);
            end
          end
          // view follows the cursor onto the bottom row, or starts at line 0 when the cursor is near the top
          if (line_q < vtop_q || line_q - vtop_q >= ROWS) begin
            vtop_q = (line_q >= ROWS - 1) ? line_q - (ROWS - 1) : 0;
          end
          update_visibility();
        end
      end
      tcs_pkg::MODE_SCROLL: begin
        target = vtop_q + int'(amt);
        if (target < 0) vtop_q = 0;
        else if (target > line_q) vtop_q = line_q;
        else vtop_q = target;
        update_visibility();
      end
      tcs_pkg::MODE_CLEAR: begin
        col_q = 0;
        step_line(ovf);
        vtop_q = line_q;
        for (int r = 0; r < ROWS && line_q + r < LINES; r++) begin
          for (int c = 0; c < COLS; c++) begin
            char_store[(line_q + r)*COLS + c] = tcs_pkg::CHAR_BLANK;
          end
        end
        update_visibility();
      end
      tcs_pkg::MODE_READ: begin
        ln = vtop_q + int'(rrow);
        res.rch = tcs_pkg::CHAR_BLANK;
        if (rrow < ROWS && rcol < COLS && ln < LINES) res.rch = char_store[ln*COLS + rcol];
        res.rattr = attr_q;
      end
      default: ;
    endcase
    res.col  = 7'(col_q);
    res.vis  = shown_q;
    res.vtop = 10'(vtop_q);
    res.line = 10'(line_q);
    res.ovf  = ovf;
    if (shown_q) begin
      res.row = 5'(line_q - vtop_q);
      res.pos = 11'((line_q - vtop_q)*COLS + col_q);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    if (!rst_ni) begin
      col_q   = 0;
      line_q  = 0;
      vtop_q  = 0;
      shown_q = 1'b1;
      attr_q  = tcs_pkg::ATTR_RESET;
      for (int i = 0; i < LINES*COLS; i++) char_store[i] = tcs_pkg::CHAR_BLANK;
      expected_results.delete();
      outstanding_o      <= 0;
      cursor_line_pred_o <= 0;
    end else begin
      // one operation in flight: the result is retired before a new one is taken
      if (done_o === 1'b1) begin
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t ns: result transfer with no operation outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          compare_field("cursor_col", want.col, cursor_col_o);
          compare_field("cursor_row", want.row, cursor_row_o);
          compare_field("cursor_position", want.pos, cursor_position_o);
          compare_field("cursor_visible", want.vis, cursor_visible_o);
          compare_field("view_top", want.vtop, view_top_o);
          compare_field("cursor_line", want.line, cursor_line_o);
          compare_field("read_char", want.rch, read_char_o);
          compare_field("read_attr", want.rattr, read_attr_o);
          compare_field("overflow", want.ovf, overflow_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) attr_q = cfg_data_i;
      if (start && busy === 1'b0) begin
        predict_console_op(tcs_pkg::mode_e'(mode_i), char_code_i, scroll_amount_i,
                           read_row_i, read_col_i, want);
        expected_results.push_back(want);
      end
      outstanding_o      <= expected_results.size();
      cursor_line_pred_o <= line_q;
    end
  end

endmodule

// ===== bench/tb_text_console_scrollback.sv =====
// top of the text console testbench: clock, reset, operation and attribute stimulus, verdict
// depends on tcs_pkg, text_console_scrollback and tcs_console_checker

module tb_text_console_scrollback;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2100;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = tcs_pkg::MODE_PUT;
  logic [7:0]         char_code_i = '0;
  logic signed [10:0] scroll_amount_i = '0;
  logic [4:0]         read_row_i = '0;
  logic [6:0]         read_col_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i = '0;
  logic               done_o;
  logic [6:0]         cursor_col_o;
  logic [4:0]         cursor_row_o;
  logic [10:0]        cursor_position_o;
  logic               cursor_visible_o;
  logic [9:0]         view_top_o;
  logic [9:0]         cursor_line_o;
  logic [7:0]         read_char_o;
  logic [7:0]         read_attr_o;
  logic               overflow_o;

  int fail_count;
  int outstanding;
  int line_pred;
  int burst_left = 0;
  int quiet_cycles = 0;

  text_console_scrollback i_dut (.*);

  tcs_console_checker i_checker (
    .*,
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .cursor_line_pred_o(line_pred)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // the clearing pass after reset is long, so the limit sits well above it
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_op(input tcs_pkg::mode_e op, input logic [7:0] ch,
                         input logic signed [10:0] amt,
                         input logic [4:0] rrow, input logic [6:0] rcol);
    int gap;
    mode_i          <= op;
    char_code_i     <= ch;
    scroll_amount_i <= amt;
    read_row_i      <= rrow;
    read_col_i      <= rcol;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy !== 1'b0);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    wait_idle();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  // unused operand ports carry random noise on every transfer
  task automatic random_op(input int newline_pct);
    logic [7:0]         ch;
    logic signed [10:0] amt;
    logic [4:0]         rrow;
    logic [6:0]         rcol;
    tcs_pkg::mode_e     op;
    int                 pick;
    ch   = 8'($urandom);
    amt  = 11'($urandom);
    rrow = 5'($urandom);
    rcol = 7'($urandom);
    op   = tcs_pkg::MODE_PUT;
    pick = $urandom_range(0, 99);
    if (pick < newline_pct) begin
      ch = $urandom_range(0, 1) ? tcs_pkg::CHAR_LF : tcs_pkg::CHAR_CR;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = tcs_pkg::MODE_PUT;
      end else if (pick < 58) begin
        ch = tcs_pkg::CHAR_BS;
      end else if (pick < 72) begin
        op = tcs_pkg::MODE_SCROLL;
        if ($urandom_range(0, 1)) amt = 11'(int'($urandom_range(0, 60)) - 30);
      end else if (pick < 97) begin
        op = tcs_pkg::MODE_READ;
        if ($urandom_range(0, 4) != 0) begin
          rrow = 5'($urandom_range(0, 24));
          rcol = 7'($urandom_range(0, 79));
        end
      end else begin
        op = tcs_pkg::MODE_CLEAR;
      end
    end
    send_op(op, ch, amt, rrow, rcol);
    if ($urandom_range(0, 99) == 0) wait_idle();
  endtask

  initial begin
    int climb;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, attribute still at its reset value
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, tcs_pkg::CHAR_BS, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, 8'hFF, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, 8'h41, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd0, 7'd1);
    send_op(tcs_pkg::MODE_READ, 8'hFF, -11'sd1, 5'd31, 7'd127);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd24, 7'd79);
    send_op(tcs_pkg::MODE_PUT, tcs_pkg::CHAR_BS, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, tcs_pkg::CHAR_LF, 11'sd0, 5'd0, 7'd0);
    // backspace at column 0 wraps to the previous line
    send_op(tcs_pkg::MODE_PUT, tcs_pkg::CHAR_BS, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, tcs_pkg::CHAR_CR, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_PUT, 8'h7E, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_SCROLL, 8'h00, 11'sh400, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_SCROLL, 8'h00, 11'sd1023, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_SCROLL, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_SCROLL, 8'h00, -11'sd1, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_CLEAR, 8'hFF, 11'sd1023, 5'd31, 7'd127);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd0, 7'd0);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd25, 7'd0);
    send_op(tcs_pkg::MODE_READ, 8'h00, 11'sd0, 5'd0, 7'd80);

    write_attribute(8'h00);
    repeat (400) random_op(25);

    // newline-heavy stretch to walk the cursor toward the end of the store
    write_attribute(8'hFF);
    climb = 0;
    while (line_pred < 1015 && climb < 1500) begin
      random_op(75);
      climb++;
    end

    write_attribute(8'($urandom));
    repeat (300) random_op(25);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tcs_pkg.sv
rtl/core/tcs_ram.sv
rtl/core/text_console_scrollback.sv
bench/tcs_console_checker.sv
bench/tb_text_console_scrollback.sv
